// ===== hw/rtl/ecr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecr_pkg
// Shared widths, constants and types of the ellipsoid curvature radii pipeline.
// ----------------------------------------------------------------------------
package ecr_pkg;

  localparam int unsigned AXIS_W     = 39;
  localparam int unsigned INVF_W     = 48;
  localparam int unsigned LAT_W      = 32;
  localparam int unsigned RAD_W      = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_MAJOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FLAT   = 2'd1;

  // angles in units of 2^-24 degree
  localparam logic [32:0] DEG45  = 33'd754974720;
  localparam logic [32:0] DEG90  = 33'd1509949440;
  localparam logic [32:0] DEG180 = 33'd3019898880;

  // pi/180 * 64 in Q32
  localparam logic [32:0] RAD_PER_UNIT = 33'd4797524517;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // series terms, divisors (n-1)*n of each step
  localparam int unsigned SERIES_N    = 6;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned SIN_DIV [SERIES_N] = '{6, 20, 42, 72, 110, 156};
  localparam int unsigned COS_DIV [SERIES_N] = '{2, 12, 30, 56, 90, 132};

  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned QUOT_BITS  = 63;

  localparam logic [RAD_W-1:0] RADIUS_MAX = '1;

  // values riding along the product chain
  typedef struct packed {
    logic [63:0] q;
    logic [63:0] r1;
    logic [63:0] r2;
    logic        hzero;
  } chain_t;

endpackage

// ===== hw/rtl/ellipsoid_curvature_radii.sv =====
// ----------------------------------------------------------------------------
// ellipsoid_curvature_radii
// Meridian, prime-vertical and conformal-sphere radii of the configured
// ellipsoid at a geodetic latitude.
// ----------------------------------------------------------------------------
// path: an accepted request passes the trig, h terms, square root, divide and
//   product chain stages and the output register before out_valid rises
// throughput: one request per cycle; the whole pipeline holds while the output
//   register and its skid entry are both full, which raises in_stall
// reset: rst clears all valid bits, the skid entry and both configuration
//   registers; normalized flattening terms settle through registers after a write
// ----------------------------------------------------------------------------
module ellipsoid_curvature_radii (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ecr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ecr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ecr_pkg::LAT_W-1:0]    latitude,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ecr_pkg::RAD_W-1:0]           meridian_radius,
  output logic [ecr_pkg::RAD_W-1:0]           prime_vertical_radius,
  output logic [ecr_pkg::RAD_W-1:0]           conformal_radius,
  output logic                                saturated
);
  import ecr_pkg::*;

  localparam int unsigned NGRP     = 6;
  localparam int unsigned NORM_MSB = 30;

  function automatic logic [RAD_W-1:0] clip(input logic [63:0] r);
    return (r > {24'b0, RADIUS_MAX}) ? RADIUS_MAX : r[RAD_W-1:0];
  endfunction

  // configuration
  logic [AXIS_W-1:0] semi_major_axis;
  logic [INVF_W-1:0] inverse_flattening;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      semi_major_axis    <= '0;
      inverse_flattening <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEMI_MAJOR: semi_major_axis    <= cfg_data[AXIS_W-1:0];
        REG_INV_FLAT:   inverse_flattening <= cfg_data[INVF_W-1:0];
        default: ;
      endcase
    end
  end

  // normalize F and |F-1| so that the larger lies in [2^30, 2^31)
  logic [47:0] b_c;
  logic [47:0] na1;
  logic [47:0] nb1;
  logic [47:0] nm1;

  assign b_c = (inverse_flattening >= 48'h1_0000_0000) ?
               (inverse_flattening - 48'h1_0000_0000) :
               (48'h1_0000_0000 - inverse_flattening);

  always_ff @(posedge clk) begin
    na1 <= inverse_flattening;
    nb1 <= b_c;
    nm1 <= (inverse_flattening > b_c) ? inverse_flattening : b_c;
  end

  logic [NGRP-1:0] grp_nz_c;
  logic [2:0]      grp_lead_c [NGRP];
  logic [NGRP-1:0] grp_nz;
  logic [2:0]      grp_lead   [NGRP];
  logic [47:0]     na2;
  logic [47:0]     nb2;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nz_c[g]   = |nm1[g*8 +: 8];
      grp_lead_c[g] = '0;
      for (int i = 0; i < 8; i++) begin
        if (nm1[g*8+i]) grp_lead_c[g] = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_nz   <= grp_nz_c;
    grp_lead <= grp_lead_c;
    na2      <= na1;
    nb2      <= nb1;
  end

  logic [5:0]  pos_c;
  logic [5:0]  pos3;
  logic [47:0] na3;
  logic [47:0] nb3;

  always_comb begin
    pos_c = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_nz[g]) pos_c = 6'(g * 8) + {3'b0, grp_lead[g]};
    end
  end

  always_ff @(posedge clk) begin
    pos3 <= pos_c;
    na3  <= na2;
    nb3  <= nb2;
  end

  logic [5:0]  sh;
  logic [47:0] a_w;
  logic [47:0] b_w;
  logic [30:0] norm_a;
  logic [30:0] norm_b;

  always_comb begin
    if (pos3 >= 6'(NORM_MSB)) begin
      sh  = pos3 - 6'(NORM_MSB);
      a_w = na3 >> sh;
      b_w = nb3 >> sh;
    end else begin
      sh  = 6'(NORM_MSB) - pos3;
      a_w = na3 << sh;
      b_w = nb3 << sh;
    end
  end

  always_ff @(posedge clk) begin
    norm_a <= a_w[30:0];
    norm_b <= b_w[30:0];
  end

  // pipeline advance and output buffering
  logic en;
  logic skid_v;

  assign en       = !skid_v;
  assign in_stall = skid_v;

  logic        tv;
  logic [30:0] s_q30;
  logic [30:0] c_q30;

  ecr_trig u_trig (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (in_valid),
    .latitude (latitude),
    .out_v    (tv),
    .s_q30    (s_q30),
    .c_q30    (c_q30)
  );

  // h^2 = (A c)^2 + (B s)^2
  logic [61:0] hc_p;
  logic [61:0] hs_p;
  logic        hv;
  logic [31:0] hc;
  logic [31:0] hs;

  assign hc_p = norm_a * c_q30;
  assign hs_p = norm_b * s_q30;

  always_ff @(posedge clk) begin
    if (rst) hv <= 1'b0;
    else if (en) hv <= tv;
    if (en) begin
      hc <= hc_p[61:30];
      hs <= hs_p[61:30];
    end
  end

  logic        qv;
  logic [63:0] hc2;
  logic [63:0] hs2;

  always_ff @(posedge clk) begin
    if (rst) qv <= 1'b0;
    else if (en) qv <= hv;
    if (en) begin
      hc2 <= hc * hc;
      hs2 <= hs * hs;
    end
  end

  logic        sv;
  logic [63:0] rad_sum;

  always_ff @(posedge clk) begin
    if (rst) sv <= 1'b0;
    else if (en) sv <= qv;
    if (en) rad_sum <= hc2 + hs2;
  end

  logic        rv;
  logic [31:0] h;

  ecr_root u_root (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (sv),
    .radicand (rad_sum),
    .out_v    (rv),
    .root     (h)
  );

  logic        dv;
  logic [62:0] p_q32;
  logic [62:0] q_q32;
  logic        hzero;

  ecr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (rv),
    .num_a    (norm_a),
    .num_b    (norm_b),
    .divisor  (h),
    .out_v    (dv),
    .quot_a   (p_q32),
    .quot_b   (q_q32),
    .div_zero (hzero)
  );

  // r1 = a p, r2 = r1 q, r3 = r2 q
  chain_t      side0;
  chain_t      side1;
  chain_t      side1_fwd;
  chain_t      side2;
  chain_t      side2_fwd;
  chain_t      side3;
  logic        m1v;
  logic        m2v;
  logic        m3v;
  logic [63:0] r1;
  logic [63:0] r2;
  logic [63:0] r3;

  always_comb begin
    side0       = '0;
    side0.q     = {1'b0, q_q32};
    side0.hzero = hzero;
    side1_fwd    = side1;
    side1_fwd.r1 = r1;
    side2_fwd    = side2;
    side2_fwd.r2 = r2;
  end

  ecr_mulq u_mul_prime (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (dv),
    .x        ({25'b0, semi_major_axis}),
    .y        ({1'b0, p_q32}),
    .side_in  (side0),
    .out_v    (m1v),
    .prod     (r1),
    .side_out (side1)
  );

  ecr_mulq u_mul_conf (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (m1v),
    .x        (r1),
    .y        (side1.q),
    .side_in  (side1_fwd),
    .out_v    (m2v),
    .prod     (r2),
    .side_out (side2)
  );

  ecr_mulq u_mul_merid (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (m2v),
    .x        (r2),
    .y        (side2.q),
    .side_in  (side2_fwd),
    .out_v    (m3v),
    .prod     (r3),
    .side_out (side3)
  );

  // result selection: sphere, zero denominator, or clipped radii
  logic [RAD_W-1:0] mer_c;
  logic [RAD_W-1:0] pv_c;
  logic [RAD_W-1:0] cf_c;
  logic             sat_c;

  always_comb begin
    if (inverse_flattening == '0) begin
      mer_c = {1'b0, semi_major_axis};
      pv_c  = {1'b0, semi_major_axis};
      cf_c  = {1'b0, semi_major_axis};
      sat_c = 1'b0;
    end else if (side3.hzero) begin
      mer_c = RADIUS_MAX;
      pv_c  = RADIUS_MAX;
      cf_c  = RADIUS_MAX;
      sat_c = 1'b1;
    end else begin
      mer_c = clip(r3);
      pv_c  = clip(side3.r1);
      cf_c  = clip(side3.r2);
      sat_c = (r3 > {24'b0, RADIUS_MAX}) || (side3.r1 > {24'b0, RADIUS_MAX}) ||
              (side3.r2 > {24'b0, RADIUS_MAX});
    end
  end

  logic             take;
  logic [RAD_W-1:0] skid_mer;
  logic [RAD_W-1:0] skid_pv;
  logic [RAD_W-1:0] skid_cf;
  logic             skid_sat;

  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (take) begin
        skid_v <= 1'b0;
      end
    end else if (m3v) begin
      if (!out_valid || take) out_valid <= 1'b1;
      else skid_v <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (take) begin
        meridian_radius       <= skid_mer;
        prime_vertical_radius <= skid_pv;
        conformal_radius      <= skid_cf;
        saturated             <= skid_sat;
      end
    end else if (m3v) begin
      if (!out_valid || take) begin
        meridian_radius       <= mer_c;
        prime_vertical_radius <= pv_c;
        conformal_radius      <= cf_c;
        saturated             <= sat_c;
      end else begin
        skid_mer <= mer_c;
        skid_pv  <= pv_c;
        skid_cf  <= cf_c;
        skid_sat <= sat_c;
      end
    end
  end

endmodule

// ===== hw/rtl/ecr_trig.sv =====
// ----------------------------------------------------------------------------
// ecr_trig
// Folds the latitude into 0..45 degree and evaluates sin and cos in Q30 with
// a pipelined Taylor series, a multiply stage and a reciprocal divide stage
// per term.
// ----------------------------------------------------------------------------
module ecr_trig (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_v,
  input  logic signed [ecr_pkg::LAT_W-1:0]  latitude,
  output logic                              out_v,
  output logic [30:0]                       s_q30,
  output logic [30:0]                       c_q30
);
  import ecr_pkg::*;

  // fold stage
  logic [32:0] mag;
  logic [32:0] fold90;
  logic [32:0] fold45;
  logic        swap_c;

  always_comb begin
    mag    = latitude[LAT_W-1] ? (33'h1_0000_0000 - {1'b0, latitude}) : {1'b0, latitude};
    fold90 = (mag > DEG90) ? (DEG180 - mag) : mag;
    swap_c = fold90 > DEG45;
    fold45 = swap_c ? (DEG90 - fold90) : fold90;
  end

  logic        v0;
  logic [29:0] u0;
  logic        sw0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_v;
    if (en) begin
      u0  <= fold45[29:0];
      sw0 <= swap_c;
    end
  end

  // angle in radians, Q30
  logic [62:0] xprod;
  logic        v1;
  logic [29:0] x1;
  logic        sw1;

  assign xprod = {33'b0, u0} * {30'b0, RAD_PER_UNIT};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
    if (en) begin
      x1  <= xprod[61:32];
      sw1 <= sw0;
    end
  end

  // x^2 and series seeds
  logic [59:0] sqprod;
  logic [30:0] ts_r  [SERIES_N+1];
  logic [30:0] as_r  [SERIES_N+1];
  logic [30:0] tc_r  [SERIES_N+1];
  logic [30:0] ac_r  [SERIES_N+1];
  logic [29:0] xq_r  [SERIES_N+1];
  logic        sw_d  [SERIES_N+1];
  logic        vd    [SERIES_N+1];

  assign sqprod = x1 * x1;

  always_ff @(posedge clk) begin
    if (rst) vd[0] <= 1'b0;
    else if (en) vd[0] <= v1;
    if (en) begin
      ts_r[0] <= {1'b0, x1};
      as_r[0] <= {1'b0, x1};
      tc_r[0] <= Q30_ONE;
      ac_r[0] <= Q30_ONE;
      xq_r[0] <= sqprod[59:30];
      sw_d[0] <= sw1;
    end
  end

  logic [29:0] vs_m [SERIES_N];
  logic [29:0] vc_m [SERIES_N];
  logic [30:0] as_m [SERIES_N];
  logic [30:0] ac_m [SERIES_N];
  logic [29:0] xq_m [SERIES_N];
  logic        sw_m [SERIES_N];
  logic        vm   [SERIES_N];

  for (genvar k = 0; k < SERIES_N; k++) begin : g_term
    localparam longint unsigned DS = longint'(SIN_DIV[k]);
    localparam longint unsigned DC = longint'(COS_DIV[k]);
    localparam logic [37:0] RS = 38'(((64'd1 << RECIP_SHIFT) + DS - 64'd1) / DS);
    localparam logic [37:0] RC = 38'(((64'd1 << RECIP_SHIFT) + DC - 64'd1) / DC);

    logic [60:0] ps;
    logic [60:0] pc;
    logic [67:0] qs;
    logic [67:0] qc;
    logic [30:0] as_nx;
    logic [30:0] ac_nx;

    // term times x^2
    assign ps = ts_r[k] * xq_r[k];
    assign pc = tc_r[k] * xq_r[k];

    always_ff @(posedge clk) begin
      if (rst) vm[k] <= 1'b0;
      else if (en) vm[k] <= vd[k];
      if (en) begin
        vs_m[k] <= ps[59:30];
        vc_m[k] <= pc[59:30];
        as_m[k] <= as_r[k];
        ac_m[k] <= ac_r[k];
        xq_m[k] <= xq_r[k];
        sw_m[k] <= sw_d[k];
      end
    end

    // exact floor divide by a small constant through a ceiling reciprocal
    assign qs = vs_m[k] * RS;
    assign qc = vc_m[k] * RC;

    if ((k % 2) == 0) begin : g_sub
      assign as_nx = as_m[k] - {1'b0, qs[67:38]};
      assign ac_nx = ac_m[k] - {1'b0, qc[67:38]};
    end else begin : g_add
      assign as_nx = as_m[k] + {1'b0, qs[67:38]};
      assign ac_nx = ac_m[k] + {1'b0, qc[67:38]};
    end

    always_ff @(posedge clk) begin
      if (rst) vd[k+1] <= 1'b0;
      else if (en) vd[k+1] <= vm[k];
      if (en) begin
        ts_r[k+1] <= {1'b0, qs[67:38]};
        tc_r[k+1] <= {1'b0, qc[67:38]};
        as_r[k+1] <= as_nx;
        ac_r[k+1] <= ac_nx;
        xq_r[k+1] <= xq_m[k];
        sw_d[k+1] <= sw_m[k];
      end
    end
  end

  // clip and undo the 45 degree fold
  logic [30:0] sn;
  logic [30:0] cn;

  assign sn = (as_r[SERIES_N] > Q30_ONE) ? Q30_ONE : as_r[SERIES_N];
  assign cn = (ac_r[SERIES_N] > Q30_ONE) ? Q30_ONE : ac_r[SERIES_N];

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (en) out_v <= vd[SERIES_N];
    if (en) begin
      s_q30 <= sw_d[SERIES_N] ? cn : sn;
      c_q30 <= sw_d[SERIES_N] ? sn : cn;
    end
  end

endmodule

// ===== hw/rtl/ecr_root.sv =====
// ----------------------------------------------------------------------------
// ecr_root
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ecr_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_v,
  input  logic [63:0] radicand,
  output logic        out_v,
  output logic [31:0] root
);
  import ecr_pkg::*;

  logic [63:0] n_r [ROOT_STEPS];
  logic [63:0] r_r [ROOT_STEPS];
  logic        v_r [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);

    logic [63:0] n_in;
    logic [63:0] r_in;
    logic        v_in;
    logic [63:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign n_in = radicand;
      assign r_in = '0;
      assign v_in = in_v;
    end else begin : g_next
      assign n_in = n_r[k-1];
      assign r_in = r_r[k-1];
      assign v_in = v_r[k-1];
    end

    assign trial = r_in + BIT;
    assign take  = n_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_in;
      if (en) begin
        n_r[k] <= take ? (n_in - trial) : n_in;
        r_r[k] <= take ? ((r_in >> 1) + BIT) : (r_in >> 1);
      end
    end
  end

  assign out_v = v_r[ROOT_STEPS-1];
  assign root  = r_r[ROOT_STEPS-1][31:0];

endmodule

// ===== hw/rtl/ecr_div.sv =====
// ----------------------------------------------------------------------------
// ecr_div
// Pipelined restoring divider: two Q32 quotients over a shared divisor,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module ecr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_v,
  input  logic [30:0] num_a,
  input  logic [30:0] num_b,
  input  logic [31:0] divisor,
  output logic        out_v,
  output logic [62:0] quot_a,
  output logic [62:0] quot_b,
  output logic        div_zero
);
  import ecr_pkg::*;

  logic [31:0] ra_r [QUOT_BITS];
  logic [31:0] rb_r [QUOT_BITS];
  logic [62:0] wa_r [QUOT_BITS];
  logic [62:0] wb_r [QUOT_BITS];
  logic [31:0] d_r  [QUOT_BITS];
  logic        z_r  [QUOT_BITS];
  logic        v_r  [QUOT_BITS];

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
    logic [31:0] ra_in;
    logic [31:0] rb_in;
    logic [62:0] wa_in;
    logic [62:0] wb_in;
    logic [31:0] d_in;
    logic        z_in;
    logic        v_in;
    logic [32:0] ta;
    logic [32:0] tb;
    logic        ga;
    logic        gb;
    logic [32:0] sa;
    logic [32:0] sb;

    if (k == 0) begin : g_first
      assign ra_in = '0;
      assign rb_in = '0;
      assign wa_in = {num_a, 32'b0};
      assign wb_in = {num_b, 32'b0};
      assign d_in  = divisor;
      assign z_in  = divisor == 32'd0;
      assign v_in  = in_v;
    end else begin : g_next
      assign ra_in = ra_r[k-1];
      assign rb_in = rb_r[k-1];
      assign wa_in = wa_r[k-1];
      assign wb_in = wb_r[k-1];
      assign d_in  = d_r[k-1];
      assign z_in  = z_r[k-1];
      assign v_in  = v_r[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign ta = {ra_in, wa_in[62]};
    assign tb = {rb_in, wb_in[62]};
    assign ga = ta >= {1'b0, d_in};
    assign gb = tb >= {1'b0, d_in};
    assign sa = ta - {1'b0, d_in};
    assign sb = tb - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_in;
      if (en) begin
        ra_r[k] <= ga ? sa[31:0] : ta[31:0];
        rb_r[k] <= gb ? sb[31:0] : tb[31:0];
        wa_r[k] <= {wa_in[61:0], ga};
        wb_r[k] <= {wb_in[61:0], gb};
        d_r[k]  <= d_in;
        z_r[k]  <= z_in;
      end
    end
  end

  assign out_v    = v_r[QUOT_BITS-1];
  assign quot_a   = wa_r[QUOT_BITS-1];
  assign quot_b   = wb_r[QUOT_BITS-1];
  assign div_zero = z_r[QUOT_BITS-1];

endmodule

// ===== hw/rtl/ecr_mulq.sv =====
// ----------------------------------------------------------------------------
// ecr_mulq
// 64 x 64 Q32 product, floor(x*y / 2^32) capped at 2^63, built from four
// 32 x 32 partial products over three stages.
// ----------------------------------------------------------------------------
module ecr_mulq (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  logic [63:0]    x,
  input  logic [63:0]    y,
  input  ecr_pkg::chain_t side_in,
  output logic           out_v,
  output logic [63:0]    prod,
  output ecr_pkg::chain_t side_out
);
  import ecr_pkg::*;

  logic        v1;
  logic [63:0] ll;
  logic [63:0] lh;
  logic [63:0] hl;
  logic [63:0] hh;
  chain_t      side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_v;
    if (en) begin
      ll    <= x[31:0]  * y[31:0];
      lh    <= x[31:0]  * y[63:32];
      hl    <= x[63:32] * y[31:0];
      hh    <= x[63:32] * y[63:32];
      side1 <= side_in;
    end
  end

  logic        v2;
  logic [33:0] mid;
  logic [64:0] hip;
  chain_t      side2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      mid   <= {2'b0, ll[63:32]} + {2'b0, lh[31:0]} + {2'b0, hl[31:0]};
      hip   <= {1'b0, hh} + {33'b0, lh[63:32]} + {33'b0, hl[63:32]};
      side2 <= side1;
    end
  end

  logic [64:0] hi;

  assign hi = hip + {63'b0, mid[33:32]};

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (en) out_v <= v2;
    if (en) begin
      prod     <= (hi >= 65'h8000_0000) ? 64'h8000_0000_0000_0000 : {hi[31:0], mid[31:0]};
      side_out <= side2;
    end
  end

endmodule

// ===== hw/rtl/ecr_checker.sv =====
// ----------------------------------------------------------------------------
// ecr_checker
// Port-level checks of the curvature radii block, bound to the top level.
// ----------------------------------------------------------------------------
module ecr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [ecr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [ecr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic signed [ecr_pkg::LAT_W-1:0]    latitude,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [ecr_pkg::RAD_W-1:0]           meridian_radius,
  input logic [ecr_pkg::RAD_W-1:0]           prime_vertical_radius,
  input logic [ecr_pkg::RAD_W-1:0]           conformal_radius,
  input logic                                saturated
);
  import ecr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(meridian_radius) &&
      $stable(prime_vertical_radius) && $stable(conformal_radius) && $stable(saturated))
    else $error("stalled result changed");

  // a flagged result carries at least one clipped radius
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> meridian_radius == RADIUS_MAX ||
      prime_vertical_radius == RADIUS_MAX || conformal_radius == RADIUS_MAX)
    else $error("saturated without a clipped radius");

  // a delivered result frees the input side
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !in_stall)
    else $error("input still stalled after a delivered result");

  // the input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind ellipsoid_curvature_radii ecr_checker u_ecr_checker (.*);

// ===== tb/sv/ecr_radii_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_radii_checker
// Watches the configuration, latitude and radii channels of the curvature
// radii pipeline, predicts the three radii and the saturation flag of every
// accepted latitude and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module ecr_radii_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [ecr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ecr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [ecr_pkg::LAT_W-1:0]  latitude,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [ecr_pkg::RAD_W-1:0]         meridian_radius,
  input  logic [ecr_pkg::RAD_W-1:0]         prime_vertical_radius,
  input  logic [ecr_pkg::RAD_W-1:0]         conformal_radius,
  input  logic                              saturated,
  output int                                fail_count,
  output int                                radii_pending
);
  import ecr_pkg::*;

  typedef struct packed {
    logic [RAD_W-1:0] meridian;
    logic [RAD_W-1:0] prime;
    logic [RAD_W-1:0] conformal;
    logic             sat;
  } radii_t;

  localparam logic [63:0] ONE_Q30 = 64'h4000_0000;
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
  localparam logic [63:0] MAX_RAD = 64'hFF_FFFF_FFFF;

  logic [AXIS_W-1:0] axis_q16;
  logic [INVF_W-1:0] invf_q32;
  radii_t            radii_q[$];

  assign radii_pending = radii_q.size();

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // taylor series in Q30, sin starts at n=3, cos at n=2
  function automatic logic [63:0] trig_q30(logic [63:0] first, logic [63:0] x2,
                                           logic [63:0] start);
    logic [63:0] term, acc, n;
    bit neg;
    term = first;
    acc = first;
    neg = 1;
    for (n = start; n <= start + 10; n = n + 2) begin
      term = ((term * x2) >> 30) / ((n - 1) * n);
      if (neg) acc = acc - term;
      else acc = acc + term;
      neg = !neg;
    end
    return (acc > ONE_Q30) ? ONE_Q30 : acc;
  endfunction

  function automatic logic [63:0] mul_q32(logic [63:0] x, logic [63:0] y);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    if (prod[127:95] != 0) return 64'h8000_0000_0000_0000;
    return prod[95:32];
  endfunction

  function automatic radii_t predict_radii(logic [31:0] raw);
    radii_t r;
    logic [63:0] u, x, x2, sn, cs, s, c, an, bn, m, hc, hs, h, p, q, r1, r2, r3;
    bit swap;
    r = '0;
    if (invf_q32 == 0) begin
      r.meridian = axis_q16;
      r.prime = axis_q16;
      r.conformal = axis_q16;
      return r;
    end
    u = raw[31] ? (64'h1_0000_0000 - raw) : {32'd0, raw};
    if (u > DEG90) u = DEG180 - u;
    swap = 0;
    if (u > DEG45) begin
      u = DEG90 - u;
      swap = 1;
    end
    x = (u * RAD_PER_UNIT) >> 32;
    x2 = (x * x) >> 30;
    sn = trig_q30(x, x2, 3);
    cs = trig_q30(ONE_Q30, x2, 2);
    s = swap ? cs : sn;
    c = swap ? sn : cs;
    an = invf_q32;
    bn = (an >= ONE_Q32) ? an - ONE_Q32 : ONE_Q32 - an;
    m = (an > bn) ? an : bn;
    while (m >= 64'h8000_0000) begin
      an = an >> 1;
      bn = bn >> 1;
      m = m >> 1;
    end
    while (m < 64'h4000_0000) begin
      an = an << 1;
      bn = bn << 1;
      m = m << 1;
    end
    hc = (an * c) >> 30;
    hs = (bn * s) >> 30;
    h = root64(hc * hc + hs * hs);
    if (h == 0) begin
      r.meridian = RADIUS_MAX;
      r.prime = RADIUS_MAX;
      r.conformal = RADIUS_MAX;
      r.sat = 1;
      return r;
    end
    p = (an << 32) / h;
    q = (bn << 32) / h;
    r1 = mul_q32({25'd0, axis_q16}, p);
    r2 = mul_q32(r1, q);
    r3 = mul_q32(r2, q);
    r.meridian = (r3 > MAX_RAD) ? RADIUS_MAX : r3[RAD_W-1:0];
    r.prime = (r1 > MAX_RAD) ? RADIUS_MAX : r1[RAD_W-1:0];
    r.conformal = (r2 > MAX_RAD) ? RADIUS_MAX : r2[RAD_W-1:0];
    r.sat = (r1 > MAX_RAD) || (r2 > MAX_RAD) || (r3 > MAX_RAD);
    return r;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    radii_t want;
    if (rst) begin
      axis_q16 <= '0;
      invf_q32 <= '0;
      radii_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SEMI_MAJOR) axis_q16 <= cfg_data[AXIS_W-1:0];
        else if (cfg_index == REG_INV_FLAT) invf_q32 <= cfg_data[INVF_W-1:0];
      end
      if (in_valid && !in_stall) radii_q.push_back(predict_radii(latitude));
      if (out_valid && !out_stall) begin
        if (radii_q.size() == 0) begin
          $display("%0t: unexpected result m=%h pv=%h c=%h s=%b", $time,
                   meridian_radius, prime_vertical_radius, conformal_radius, saturated);
          fail_count++;
        end else begin
          want = radii_q.pop_front();
          if (meridian_radius !== want.meridian) begin
            $display("%0t: meridian_radius expected %h actual %h", $time,
                     want.meridian, meridian_radius);
            fail_count++;
          end
          if (prime_vertical_radius !== want.prime) begin
            $display("%0t: prime_vertical_radius expected %h actual %h", $time,
                     want.prime, prime_vertical_radius);
            fail_count++;
          end
          if (conformal_radius !== want.conformal) begin
            $display("%0t: conformal_radius expected %h actual %h", $time,
                     want.conformal, conformal_radius);
            fail_count++;
          end
          if (saturated !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the curvature radii pipeline through a series of ellipsoids (sphere,
// flattening one, extreme axes and flattenings, earth-like and random), with
// directed and random latitudes and random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import ecr_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 130;
  localparam logic [31:0] LAT90 = 32'd1509949440;
  localparam logic [31:0] LAT45 = 32'd754974720;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SEMI_MAJOR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [LAT_W-1:0] latitude = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [RAD_W-1:0] meridian_radius, prime_vertical_radius, conformal_radius;
  logic saturated;
  int fail_count, radii_pending;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  ellipsoid_curvature_radii uut (.*);

  ecr_radii_checker checker_i (.*);

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output stall bursts alternating with free-running stretches
  always @(negedge clk) begin
    if (quiet) begin
      out_stall = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall) begin
      out_stall = 0;
      stall_left = $urandom_range(0, 20);
    end else begin
      out_stall = 1;
      stall_left = gap_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
        (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
    // flattening terms need a few cycles to settle
    repeat (8) @(posedge clk);
  endtask

  task automatic send_latitude(logic [31:0] lat);
    int g;
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1;
    latitude = lat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (radii_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_latitude();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2 * LAT90) - LAT90;
    if (r < 80) return $urandom_range(0, 64) - 32 + (($urandom_range(0, 1)) ? LAT45 : LAT90);
    if (r < 85) return -($urandom_range(0, 64) + LAT90 - 32);
    return $urandom;
  endfunction

  task automatic pick_ellipsoid(int sel);
    logic [CFG_DATA_W-1:0] a, f;
    case (sel)
      0: begin a = 48'd6378137 << 16; f = 48'd0; end
      1: begin a = 48'd6378137 << 16; f = 48'h1_0000_0000; end
      2: begin a = {9'd0, {39{1'b1}}}; f = '1; end
      3: begin a = 48'd0; f = 48'd298 << 32 | 48'h41D_C1A1; end
      4: begin a = {9'd0, {39{1'b1}}}; f = 48'd1; end
      5: begin a = 48'd6378137 << 16; f = 48'h8000_0000; end
      6: begin a = 48'd6378137 << 16; f = (48'd298 << 32) | 48'h41D_C1A1; end
      default: begin
        a = {$urandom, $urandom} & 48'h7F_FFFF_FFFF;
        case ($urandom_range(0, 3))
          0: f = {$urandom, $urandom};
          1: f = $urandom_range(250, 350) * 48'h1_0000_0000 + $urandom;
          2: f = $urandom;
          default: f = 48'h1_0000_0000 + $urandom_range(0, 3) - 1;
        endcase
      end
    endcase
    write_reg(REG_SEMI_MAJOR, a);
    write_reg(REG_INV_FLAT, f);
    // unused indexes must be ignored
    write_reg(2'd2, {$urandom, $urandom});
    write_reg(2'd3, {$urandom, $urandom});
  endtask

  initial begin
    logic [31:0] directed[$];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // earth-like ellipsoid, directed latitudes
    pick_ellipsoid(6);
    directed = '{32'd0, LAT45, LAT45 + 1, LAT45 - 1, LAT90, -LAT90, -LAT45,
                 LAT90 + 1, -LAT90 - 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'd1, 32'd2 * LAT90, 32'd3 * LAT45, 32'hA5A5_5A5A, 32'h5A5A_A5A5};
    foreach (directed[i]) send_latitude(directed[i]);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      pick_ellipsoid(ph < 7 ? ph : 7);
      quiet = (ph % 4 == 3);
      send_latitude(LAT90);
      send_latitude(32'd0);
      for (int k = 0; k < 96; k++) send_latitude(random_latitude());
      drain();
    end
    quiet = 0;

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
